// ===== sv/height_hash_checkpoint_table_core_assert.svh =====
// Assertion macros for the checkpoint table core.
// Included by the top level; no other dependencies.
`ifndef HEIGHT_HASH_CHECKPOINT_TABLE_CORE_ASSERT_SVH
`define HEIGHT_HASH_CHECKPOINT_TABLE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define HHC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define HHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define HHC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`define HHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/hhc_pkg.sv =====
// Shared types and constants of the checkpoint table core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hhc_pkg;

   localparam int unsigned HEIGHT_W = 64;
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned HASH_W   = 4 * WORD_W;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_CHECK = 2'd1,
      CMD_ZONE  = 2'd2,
      CMD_ALT   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic start_scan;
      logic scan_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/hhc_if.sv =====
// Request and response channel interfaces of the checkpoint table core.
// Depends on hhc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hhc_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [hhc_pkg::HEIGHT_W-1:0]  height;
   logic [hhc_pkg::HEIGHT_W-1:0]  alt_height;
   logic [hhc_pkg::WORD_W-1:0]    hash_word_0;
   logic [hhc_pkg::WORD_W-1:0]    hash_word_1;
   logic [hhc_pkg::WORD_W-1:0]    hash_word_2;
   logic [hhc_pkg::WORD_W-1:0]    hash_word_3;

   modport source (output valid, cmd, height, alt_height,
                   hash_word_0, hash_word_1, hash_word_2, hash_word_3,
                   input ready);
   modport sink   (input valid, cmd, height, alt_height,
                   hash_word_0, hash_word_1, hash_word_2, hash_word_3,
                   output ready);
endinterface

interface hhc_rsp_if;
   logic valid;
   logic ready;
   logic answer;
   logic is_checkpoint;
   logic table_full;

   modport source (output valid, answer, is_checkpoint, table_full, input ready);
   modport sink   (input valid, answer, is_checkpoint, table_full, output ready);
endinterface

`default_nettype wire

// ===== sv/hhc_ctrl.sv =====
// Controller state machine of the checkpoint table core.
// Depends on hhc_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hhc_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   input  hhc_pkg::dp_status_type status,
   output hhc_pkg::ctl_cmd_type  ctl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      accept        = req_valid && req_ready;
      out_free      = !rsp_valid_ff || rsp_ready;
      ctl.load_req  = accept;
      ctl.scan_step = (state_ff == ST_SCAN);
      ctl.commit    = (state_ff == ST_FINISH) && out_free;
      rsp_valid     = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= status.start_scan ? ST_SCAN : ST_FINISH;
               end
            end
            ST_SCAN: begin
               if (status.scan_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (ctl.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/hhc_datapath.sv =====
// Datapath of the checkpoint table core: slot memories, scan pipeline,
// accumulators and the response register. Depends on hhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hhc_datapath #(
   parameter int unsigned ENTRIES = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [1:0]                          req_cmd,
   input  wire  [hhc_pkg::HEIGHT_W-1:0]        req_height,
   input  wire  [hhc_pkg::HEIGHT_W-1:0]        req_alt_height,
   input  wire  [hhc_pkg::HASH_W-1:0]          req_hash,
   input  hhc_pkg::ctl_cmd_type                ctl,
   output hhc_pkg::dp_status_type              status,
   output logic                                rsp_answer,
   output logic                                rsp_is_checkpoint,
   output logic                                rsp_table_full
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

   logic [hhc_pkg::HEIGHT_W-1:0] height_mem [ENTRIES];
   logic [hhc_pkg::HASH_W-1:0]   hash_mem   [ENTRIES];

   hhc_pkg::cmd_type             cmd_ff;
   logic [hhc_pkg::HEIGHT_W-1:0] height_ff;
   logic [hhc_pkg::HEIGHT_W-1:0] alt_height_ff;
   logic [hhc_pkg::HASH_W-1:0]   hash_ff;

   logic [CNT_W-1:0]             count_ff;
   logic [hhc_pkg::HEIGHT_W-1:0] highest_ff;
   logic [IDX_W-1:0]             idx_ff;

   logic                         rd_valid_ff;
   logic [hhc_pkg::HEIGHT_W-1:0] rd_height_ff;
   logic [hhc_pkg::HASH_W-1:0]   rd_hash_ff;

   logic                         found_ff;
   logic                         hash_ok_ff;
   logic                         best_found_ff;
   logic [hhc_pkg::HEIGHT_W-1:0] best_ff;

   logic                         rsp_answer_ff;
   logic                         rsp_is_cp_ff;
   logic                         rsp_full_ff;

   hhc_pkg::cmd_type             in_cmd;
   logic                         table_full;
   logic                         do_insert;
   logic                         answer_in;
   logic                         is_cp_in;
   logic                         full_in;
   logic                         hit;
   logic                         better;

   always_comb begin
      in_cmd     = hhc_pkg::cmd_type'(req_cmd);
      table_full = (count_ff == CNT_FULL);

      status.start_scan = (count_ff != '0) &&
                          ((in_cmd == hhc_pkg::CMD_ADD) ||
                           (in_cmd == hhc_pkg::CMD_CHECK) ||
                           ((in_cmd == hhc_pkg::CMD_ALT) && (req_alt_height != '0)));
      status.scan_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

      hit    = rd_valid_ff && (rd_height_ff == height_ff);
      better = rd_valid_ff && (rd_height_ff <= height_ff) &&
               (!best_found_ff || (rd_height_ff > best_ff));

      answer_in = 1'b0;
      is_cp_in  = 1'b0;
      full_in   = 1'b0;
      do_insert = 1'b0;
      unique case (cmd_ff)
         hhc_pkg::CMD_ADD: begin
            if (found_ff) begin
               answer_in = hash_ok_ff;
            end else if (table_full) begin
               full_in = 1'b1;
            end else begin
               answer_in = 1'b1;
               do_insert = 1'b1;
            end
         end
         hhc_pkg::CMD_CHECK: begin
            is_cp_in  = found_ff;
            answer_in = found_ff ? hash_ok_ff : 1'b1;
         end
         hhc_pkg::CMD_ZONE: begin
            answer_in = (count_ff != '0) && (height_ff <= highest_ff);
         end
         hhc_pkg::CMD_ALT: begin
            answer_in = (alt_height_ff != '0) &&
                        (!best_found_ff || (best_ff < alt_height_ff));
         end
         default: begin
            answer_in = 1'b0;
         end
      endcase
   end

   // Table memories: one write port at the fill count, one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.commit && do_insert) begin
         height_mem[count_ff[IDX_W-1:0]] <= height_ff;
         hash_mem[count_ff[IDX_W-1:0]]   <= hash_ff;
      end
      if (ctl.scan_step) begin
         rd_height_ff <= height_mem[idx_ff];
         rd_hash_ff   <= hash_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         highest_ff  <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctl.scan_step;
         if (ctl.commit && do_insert) begin
            count_ff <= count_ff + CNT_W'(1);
            if ((count_ff == '0) || (height_ff > highest_ff)) begin
               highest_ff <= height_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff          <= in_cmd;
         height_ff       <= req_height;
         alt_height_ff   <= req_alt_height;
         hash_ff         <= req_hash;
         idx_ff          <= '0;
         found_ff        <= 1'b0;
         hash_ok_ff      <= 1'b0;
         best_found_ff   <= 1'b0;
         best_ff         <= '0;
      end else begin
         if (ctl.scan_step) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (hit) begin
            found_ff   <= 1'b1;
            hash_ok_ff <= (rd_hash_ff == hash_ff);
         end
         if (better) begin
            best_found_ff <= 1'b1;
            best_ff       <= rd_height_ff;
         end
      end
      if (ctl.commit) begin
         rsp_answer_ff <= answer_in;
         rsp_is_cp_ff  <= is_cp_in;
         rsp_full_ff   <= full_in;
      end
   end

   assign rsp_answer        = rsp_answer_ff;
   assign rsp_is_checkpoint = rsp_is_cp_ff;
   assign rsp_table_full    = rsp_full_ff;

endmodule

`default_nettype wire

// ===== sv/height_hash_checkpoint_table_core.sv =====
// Checkpoint table core: maps 64-bit heights to 256-bit hashes.
// Add, check and alternative queries scan the filled slots one per cycle, then pass the
// drain state; zone queries, an empty table and a zero alternative height skip the scan.
// A new item is accepted the cycle after the result is loaded into the output register.
// Synchronous reset empties the table by clearing the fill count; no memory sweep.
// Depends on hhc_pkg, hhc_if, hhc_ctrl, hhc_datapath and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "height_hash_checkpoint_table_core_assert.svh"

module height_hash_checkpoint_table_core #(
   parameter int unsigned ENTRIES = 64
) (
   input wire         clock,
   input wire         reset,
   hhc_req_if.sink    req_ch,
   hhc_rsp_if.source  rsp_ch
);

   hhc_pkg::ctl_cmd_type   ctl;
   hhc_pkg::dp_status_type status;

   hhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .ctl       (ctl)
   );

   hhc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_ch.cmd),
      .req_height        (req_ch.height),
      .req_alt_height    (req_ch.alt_height),
      .req_hash          ({req_ch.hash_word_3, req_ch.hash_word_2,
                           req_ch.hash_word_1, req_ch.hash_word_0}),
      .ctl               (ctl),
      .status            (status),
      .rsp_answer        (rsp_ch.answer),
      .rsp_is_checkpoint (rsp_ch.is_checkpoint),
      .rsp_table_full    (rsp_ch.table_full)
   );

   `HHC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "item accepted while busy")
   `HHC_ASSERT_IMP(a_full_excl, clock, reset, rsp_ch.valid && rsp_ch.table_full, !rsp_ch.answer && !rsp_ch.is_checkpoint, "full flag with other result bits")
   `HHC_ASSERT_IMP(a_commit_one, clock, reset, ctl.commit, !ctl.scan_step && !ctl.load_req, "commit overlaps scan or load")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for height_hash_checkpoint_table_core: add, check, zone and
// alternative commands are predicted in the bench and compared against every response.
// Depends on hhc_pkg, hhc_if and the core itself.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned ENTRIES     = 64;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned SETTLE      = ENTRIES + 16;
   localparam int          HOLD_CYCLES = 400;
   localparam int unsigned PHASE_ITEMS = 482;

   typedef logic [3:0][hhc_pkg::WORD_W-1:0] hash_type;

   typedef struct packed {
      hhc_pkg::cmd_type              cmd;
      logic [hhc_pkg::HEIGHT_W-1:0]  height;
      logic [hhc_pkg::HEIGHT_W-1:0]  alt_height;
      hash_type                      hash;
   } checkpoint_req_type;

   typedef struct packed {
      logic answer;
      logic is_checkpoint;
      logic table_full;
   } checkpoint_rsp_type;

   logic clock = 1'b0;
   logic reset;

   hhc_req_if req_bus ();
   hhc_rsp_if rsp_bus ();

   height_hash_checkpoint_table_core #(.ENTRIES(ENTRIES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   checkpoint_req_type           pending_cmds[$];
   checkpoint_rsp_type           expected_rsps[$];
   logic [hhc_pkg::HEIGHT_W-1:0] known_height[$];
   hash_type                     known_hash[$];

   // Bench copy of the checkpoint store.
   bit                           slot_used[ENTRIES];
   logic [hhc_pkg::HEIGHT_W-1:0] slot_height[ENTRIES];
   hash_type                     slot_hash[ENTRIES];
   int unsigned                  used_count = 0;
   logic [hhc_pkg::HEIGHT_W-1:0] top_height = '0;

   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;
   int          hold_trigger       = 0;
   int          hold_seen          = 0;
   int          hold_left          = 0;
   int          fail_count         = 0;
   int unsigned cycle_count        = 0;

   function automatic checkpoint_rsp_type apply_command(checkpoint_req_type r);
      checkpoint_rsp_type           res;
      int                           hit;
      int                           free_idx;
      bit                           found;
      logic [hhc_pkg::HEIGHT_W-1:0] best;
      res = '0;
      hit = -1;
      free_idx = -1;
      found = 1'b0;
      best = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && slot_used[i] && slot_height[i] == r.height) hit = i;
         if (free_idx < 0 && !slot_used[i]) free_idx = i;
      end
      case (r.cmd)
         hhc_pkg::CMD_ADD: begin
            if (hit >= 0) begin
               res.answer = (slot_hash[hit] == r.hash);
            end else if (free_idx < 0) begin
               res.table_full = 1'b1;
            end else begin
               slot_used[free_idx] = 1'b1;
               slot_height[free_idx] = r.height;
               slot_hash[free_idx] = r.hash;
               if (used_count == 0 || r.height > top_height) top_height = r.height;
               used_count++;
               res.answer = 1'b1;
            end
         end
         hhc_pkg::CMD_CHECK: begin
            if (hit < 0) begin
               res.answer = 1'b1;
            end else begin
               res.is_checkpoint = 1'b1;
               res.answer = (slot_hash[hit] == r.hash);
            end
         end
         hhc_pkg::CMD_ZONE: begin
            res.answer = (used_count != 0 && r.height <= top_height);
         end
         default: begin
            if (r.alt_height != 0) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_used[i] && slot_height[i] <= r.height &&
                      (!found || slot_height[i] > best)) begin
                     best = slot_height[i];
                     found = 1'b1;
                  end
               end
               res.answer = (!found || best < r.alt_height);
            end
         end
      endcase
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic hash_type rand_hash();
      return {rand64(), rand64(), rand64(), rand64()};
   endfunction

   function automatic hash_type flip_hash_bit(hash_type h);
      hash_type res;
      int       w;
      int       b;
      res = h;
      w = $urandom_range(3);
      b = $urandom_range(63);
      res[w][b] = ~res[w][b];
      return res;
   endfunction

   function automatic logic [hhc_pkg::HEIGHT_W-1:0] fresh_height();
      case ($urandom_range(3))
         0: return {32'd0, 32'($urandom_range(2000))};
         1: return rand64();
         2: return {32'hFFFF_FFFF, $urandom};
         default: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
      endcase
   endfunction

   function automatic logic [hhc_pkg::HEIGHT_W-1:0] near_height();
      logic [hhc_pkg::HEIGHT_W-1:0] base;
      if (known_height.size() == 0 || $urandom_range(4) == 0) return fresh_height();
      base = known_height[$urandom_range(known_height.size() - 1)];
      case ($urandom_range(2))
         0: return base - 64'd1;
         1: return base;
         default: return base + 64'd1;
      endcase
   endfunction

   task automatic queue_item(hhc_pkg::cmd_type cmd, logic [63:0] h, logic [63:0] ah,
                             hash_type hv);
      checkpoint_req_type it;
      bit                 seen;
      it.cmd = cmd;
      it.height = h;
      it.alt_height = ah;
      it.hash = hv;
      pending_cmds.push_back(it);
      if (cmd == hhc_pkg::CMD_ADD) begin
         seen = 1'b0;
         foreach (known_height[i]) if (known_height[i] == h) seen = 1'b1;
         if (!seen) begin
            known_height.push_back(h);
            known_hash.push_back(hv);
         end
      end
   endtask

   task automatic queue_random_item();
      int       pick;
      int       idx;
      hash_type hv;
      pick = $urandom_range(99);
      idx = (known_height.size() > 0) ? $urandom_range(known_height.size() - 1) : 0;
      if (pick < 30) begin
         if (known_height.size() == 0 || $urandom_range(5) == 0) begin
            queue_item(hhc_pkg::CMD_ADD, fresh_height(), rand64(), rand_hash());
         end else begin
            hv = $urandom_range(1) ? known_hash[idx] : flip_hash_bit(known_hash[idx]);
            queue_item(hhc_pkg::CMD_ADD, known_height[idx], rand64(), hv);
         end
      end else if (pick < 55) begin
         if (known_height.size() > 0 && $urandom_range(4) < 3) begin
            hv = $urandom_range(1) ? known_hash[idx] : flip_hash_bit(known_hash[idx]);
            queue_item(hhc_pkg::CMD_CHECK, known_height[idx], rand64(), hv);
         end else begin
            queue_item(hhc_pkg::CMD_CHECK, fresh_height(), rand64(), rand_hash());
         end
      end else if (pick < 75) begin
         queue_item(hhc_pkg::CMD_ZONE, near_height(), rand64(), rand_hash());
      end else begin
         queue_item(hhc_pkg::CMD_ALT, near_height(),
                    ($urandom_range(9) == 0) ? 64'd0 : near_height(), rand_hash());
      end
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_cmds.size() != 0 || req_bus.valid || expected_rsps.size() != 0);
   endtask

   task automatic note_failure(string what, checkpoint_rsp_type want,
                               checkpoint_rsp_type got);
      if (fail_count < 10) begin
         $display("%0t: %s: expected answer=%0b is_checkpoint=%0b table_full=%0b",
                  $time, what, want.answer, want.is_checkpoint, want.table_full);
         $display("%0t: %s: actual   answer=%0b is_checkpoint=%0b table_full=%0b",
                  $time, what, got.answer, got.is_checkpoint, got.table_full);
      end
      fail_count++;
   endtask

   // Request driver: takes the next item from the pending queue.
   always @(posedge clock) begin
      checkpoint_req_type seen_req;
      checkpoint_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            seen_req.cmd = hhc_pkg::cmd_type'(req_bus.cmd);
            seen_req.height = req_bus.height;
            seen_req.alt_height = req_bus.alt_height;
            seen_req.hash = {req_bus.hash_word_3, req_bus.hash_word_2,
                             req_bus.hash_word_1, req_bus.hash_word_0};
            expected_rsps.push_back(apply_command(seen_req));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt = pending_cmds.pop_front();
               req_bus.cmd <= nxt.cmd;
               req_bus.height <= nxt.height;
               req_bus.alt_height <= nxt.alt_height;
               req_bus.hash_word_0 <= nxt.hash[0];
               req_bus.hash_word_1 <= nxt.hash[1];
               req_bus.hash_word_2 <= nxt.hash[2];
               req_bus.hash_word_3 <= nxt.hash[3];
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here and started from the stimulus process.
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || hold_left > 0 || hold_trigger != hold_seen)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Response monitor: each item must match the oldest prediction.
   always @(posedge clock) begin
      checkpoint_rsp_type got;
      checkpoint_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.answer = rsp_bus.answer;
         got.is_checkpoint = rsp_bus.is_checkpoint;
         got.table_full = rsp_bus.table_full;
         if (expected_rsps.size() == 0) begin
            note_failure("response with nothing outstanding", '0, got);
         end else begin
            want = expected_rsps.pop_front();
            if (got.answer !== want.answer || got.is_checkpoint !== want.is_checkpoint ||
                got.table_full !== want.table_full)
               note_failure("response mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      hash_type hash_a;
      hash_type hash_b;
      hash_type ones;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = hhc_pkg::CMD_ADD;
      req_bus.height = '0;
      req_bus.alt_height = '0;
      req_bus.hash_word_0 = '0;
      req_bus.hash_word_1 = '0;
      req_bus.hash_word_2 = '0;
      req_bus.hash_word_3 = '0;
      rsp_bus.ready = 1'b0;
      hash_a = rand_hash();
      hash_b = rand_hash();
      ones = '1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      queue_item(hhc_pkg::CMD_ZONE, 64'd0, 64'd0, '0);
      queue_item(hhc_pkg::CMD_ZONE, '1, '1, ones);
      queue_item(hhc_pkg::CMD_ALT, '1, 64'd1, '0);
      queue_item(hhc_pkg::CMD_ALT, 64'd5, 64'd0, '0);
      queue_item(hhc_pkg::CMD_CHECK, 64'd0, 64'd0, '0);
      queue_item(hhc_pkg::CMD_ADD, 64'd0, '1, ones);
      queue_item(hhc_pkg::CMD_ADD, '1, 64'd0, hash_a);
      queue_item(hhc_pkg::CMD_ADD, 64'd1000, 64'd0, hash_b);
      queue_item(hhc_pkg::CMD_ADD, 64'd1000, 64'd0, hash_b);
      queue_item(hhc_pkg::CMD_ADD, 64'd1000, 64'd0, flip_hash_bit(hash_b));
      queue_item(hhc_pkg::CMD_CHECK, 64'd1000, 64'd0, hash_b);
      queue_item(hhc_pkg::CMD_CHECK, 64'd1000, 64'd0, flip_hash_bit(hash_b));
      queue_item(hhc_pkg::CMD_CHECK, '1, 64'd0, ones);
      queue_item(hhc_pkg::CMD_CHECK, 64'd0, 64'd0, ones);
      queue_item(hhc_pkg::CMD_ZONE, '1, 64'd0, '0);
      queue_item(hhc_pkg::CMD_ZONE, 64'd999, 64'd0, '0);
      queue_item(hhc_pkg::CMD_ALT, 64'd1500, 64'd1000, '0);
      queue_item(hhc_pkg::CMD_ALT, 64'd1500, 64'd1001, '0);
      queue_item(hhc_pkg::CMD_ALT, 64'd999, 64'd1, '0);
      queue_item(hhc_pkg::CMD_ALT, '1, '1, '0);
      queue_item(hhc_pkg::CMD_ALT, 64'd0, '1, '0);
      wait_drained();

      @(posedge clock);
      hold_trigger <= hold_trigger + 1;
      repeat (PHASE_ITEMS) queue_random_item();
      wait_drained();

      sender_idle_pct <= 82;
      repeat (PHASE_ITEMS) queue_random_item();
      wait_drained();

      sender_idle_pct <= 0;
      receiver_stall_pct <= 82;
      repeat (PHASE_ITEMS) queue_random_item();
      wait_drained();

      sender_idle_pct <= 23;
      receiver_stall_pct <= 23;
      repeat (PHASE_ITEMS) queue_random_item();
      wait_drained();

      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
